/* src/mma_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mma_pkg
// shared widths, codes, item and control types of the matrix multiply block
// ----------------------------------------------------------------------------
package mma_pkg;

	// field widths fixed by the item format
	localparam int ELEM_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int DIM_W      = 5;
	localparam int IDX_W      = 4;
	localparam int RES_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// arithmetic widths, all exact so no intermediate clipping is needed
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int DOT_W      = PROD_W + DIM_W;
	localparam int SA_W       = DOT_W + GAIN_W;
	localparam int SB_W       = ELEM_W + GAIN_W;
	localparam int BETA_SHIFT = 8;
	localparam int SUM_W      = SA_W + 1;
	localparam int FRAC_SHIFT = 16;
	localparam int Q_W        = SUM_W - FRAC_SHIFT;

	localparam logic signed [SUM_W-1:0] ROUND_BIAS =
		{{(SUM_W - FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT - 1){1'b0}}};
	localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W - 1){1'b1}}};
	localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W - 1){1'b0}}};

	// register reset values
	localparam logic [DIM_W-1:0]         DIM_RST   = 5'd16;
	localparam logic signed [GAIN_W-1:0] ALPHA_RST = 16'sd256;
	localparam logic signed [GAIN_W-1:0] BETA_RST  = 16'sd0;

	typedef enum logic [1:0] {
		MODE_LOAD_A = 2'd0,
		MODE_LOAD_B = 2'd1,
		MODE_LOAD_C = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIM_M = 3'd0,
		CFG_DIM_N = 3'd1,
		CFG_DIM_K = 3'd2,
		CFG_ALPHA = 3'd3,
		CFG_BETA  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_RUN    = 3'd1,
		ST_CFETCH = 3'd2,
		ST_DRAIN  = 3'd3,
		ST_SCALE  = 3'd4,
		ST_SUM    = 3'd5,
		ST_DONE   = 3'd6
	} state_t;

	typedef struct packed {
		mode_t                     mode;
		logic [IDX_W-1:0]          row_index;
		logic [IDX_W-1:0]          col_index;
		logic signed [ELEM_W-1:0]  element_value;
	} mma_in_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		logic                    saturated;
		logic                    out_of_range;
	} mma_out_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic clr;
		logic mul_en;
		logic acc_en;
		logic c_cap;
		logic scale_en;
		logic sum_en;
		logic done;
		logic oor;
	} mma_ctrl_t;

endpackage
`default_nettype wire

/* src/mma_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mma_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module mma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/mma_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mma_seq
// item intake, memory addressing and step sequencing of a result read
// ----------------------------------------------------------------------------
module mma_seq #(
	parameter int MAX_DIM = 16,
	localparam int CELLS = MAX_DIM * MAX_DIM,
	localparam int AW    = $clog2(CELLS),
	localparam int ACW   = $clog2(2 * CELLS)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	output logic                           item_ready,
	input  wire mma_pkg::mma_in_t          item,
	input  wire logic [mma_pkg::DIM_W-1:0] dim_m,
	input  wire logic [mma_pkg::DIM_W-1:0] dim_n,
	input  wire logic [mma_pkg::DIM_W-1:0] dim_k,
	input  wire logic                      out_free,
	output logic                           ac_we,
	output logic [ACW-1:0]                 ac_waddr,
	output logic                           ac_re,
	output logic [ACW-1:0]                 ac_raddr,
	output logic                           b_we,
	output logic [AW-1:0]                  b_waddr,
	output logic                           b_re,
	output logic [AW-1:0]                  b_raddr,
	output mma_pkg::mma_ctrl_t             ctrl
);

	mma_pkg::state_t state_q, state_d;

	logic [mma_pkg::IDX_W-1:0] row_q, col_q;
	logic [mma_pkg::DIM_W-1:0] kd_q, k_q, kd_eff;
	logic                      oor_q, oor_d;
	logic                      rd_s1, prod_v_s2, c_s1;
	logic                      accept, read_acc, load_ok;
	logic [AW-1:0]             cell_w, a_addr;
	logic [ACW-1:0]            c_addr;

	// intake only while idle
	assign item_ready = (state_q == mma_pkg::ST_IDLE);

	assign accept  = item_valid && item_ready;
	assign read_acc = accept && (item.mode == mma_pkg::MODE_READ);
	assign load_ok = (int'(item.row_index) < MAX_DIM) && (int'(item.col_index) < MAX_DIM);

	// dimension registers above the store size act as the store size
	assign kd_eff = (int'(dim_k) > MAX_DIM) ? mma_pkg::DIM_W'(MAX_DIM) : dim_k;
	assign oor_d  = (int'(item.row_index) >= int'(dim_m)) || (int'(item.row_index) >= MAX_DIM)
		|| (int'(item.col_index) >= int'(dim_n)) || (int'(item.col_index) >= MAX_DIM);

	// row-major cell addresses; c lives in the upper half of the a/c memory
	assign cell_w  = AW'(item.row_index * MAX_DIM + item.col_index);
	assign a_addr  = AW'(row_q * MAX_DIM + k_q);
	assign b_raddr = AW'(k_q * MAX_DIM + col_q);
	assign c_addr  = ACW'(CELLS + row_q * MAX_DIM + col_q);

	assign ac_we    = accept && load_ok
		&& (item.mode == mma_pkg::MODE_LOAD_A || item.mode == mma_pkg::MODE_LOAD_C);
	assign ac_waddr = (item.mode == mma_pkg::MODE_LOAD_C) ? ACW'(CELLS + cell_w) : ACW'(cell_w);
	assign b_we     = accept && load_ok && (item.mode == mma_pkg::MODE_LOAD_B);
	assign b_waddr  = cell_w;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mma_pkg::ST_IDLE: begin
				if (read_acc) begin
					if (oor_d) begin
						state_d = mma_pkg::ST_DONE;
					end else if (kd_eff == '0) begin
						state_d = mma_pkg::ST_CFETCH;
					end else begin
						state_d = mma_pkg::ST_RUN;
					end
				end
			end
			mma_pkg::ST_RUN: begin
				if (k_q + 1'b1 == kd_q) begin
					state_d = mma_pkg::ST_CFETCH;
				end
			end
			mma_pkg::ST_CFETCH: state_d = mma_pkg::ST_DRAIN;
			mma_pkg::ST_DRAIN:  state_d = mma_pkg::ST_SCALE;
			mma_pkg::ST_SCALE:  state_d = mma_pkg::ST_SUM;
			mma_pkg::ST_SUM:    state_d = mma_pkg::ST_DONE;
			mma_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = mma_pkg::ST_IDLE;
				end
			end
			default: state_d = mma_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ac_re         = 1'b0;
		b_re          = 1'b0;
		ac_raddr      = ACW'(a_addr);
		ctrl          = '0;
		ctrl.clr      = read_acc;
		ctrl.mul_en   = rd_s1;
		ctrl.acc_en   = prod_v_s2;
		ctrl.c_cap    = c_s1;
		ctrl.oor      = oor_q;
		case (state_q)
			mma_pkg::ST_IDLE: ;
			mma_pkg::ST_RUN: begin
				ac_re = 1'b1;
				b_re  = 1'b1;
			end
			mma_pkg::ST_CFETCH: begin
				ac_re    = 1'b1;
				ac_raddr = c_addr;
			end
			mma_pkg::ST_DRAIN: ;
			mma_pkg::ST_SCALE: ctrl.scale_en = 1'b1;
			mma_pkg::ST_SUM:   ctrl.sum_en = 1'b1;
			mma_pkg::ST_DONE:  ctrl.done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mma_pkg::ST_IDLE;
			k_q       <= '0;
			oor_q     <= 1'b0;
			rd_s1     <= 1'b0;
			prod_v_s2 <= 1'b0;
			c_s1      <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_s1     <= (state_q == mma_pkg::ST_RUN);
			prod_v_s2 <= rd_s1;
			c_s1      <= (state_q == mma_pkg::ST_CFETCH);
			if (read_acc) begin
				k_q   <= '0;
				oor_q <= oor_d;
			end else if (state_q == mma_pkg::ST_RUN) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (read_acc) begin
			row_q <= item.row_index;
			col_q <= item.col_index;
			kd_q  <= kd_eff;
		end
	end

endmodule
`default_nettype wire

/* src/mma_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mma_mac
// multiply-accumulate of the dot product, alpha/beta scaling, rounding
// ----------------------------------------------------------------------------
module mma_mac (
	input  wire logic                              clk,
	input  wire mma_pkg::mma_ctrl_t                ctrl,
	input  wire logic [mma_pkg::ELEM_W-1:0]        ac_rdata,
	input  wire logic [mma_pkg::ELEM_W-1:0]        b_rdata,
	input  wire logic signed [mma_pkg::GAIN_W-1:0] alpha_gain,
	input  wire logic signed [mma_pkg::GAIN_W-1:0] beta_gain,
	output logic signed [mma_pkg::RES_W-1:0]       result_value,
	output logic                                   saturated
);

	logic signed [mma_pkg::PROD_W-1:0] prod_s2;
	logic signed [mma_pkg::DOT_W-1:0]  dot_q;
	logic signed [mma_pkg::ELEM_W-1:0] c_q;
	logic signed [mma_pkg::SA_W-1:0]   pa_q;
	logic signed [mma_pkg::SB_W-1:0]   pb_q;
	logic [mma_pkg::SUM_W-1:0]         pa_ext, pb_ext, sum_w;
	logic [mma_pkg::Q_W-1:0]           q_w;
	logic [mma_pkg::Q_W-mma_pkg::RES_W:0] q_hi;
	logic                              fits;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s2 <= $signed(ac_rdata) * $signed(b_rdata);
		end
		if (ctrl.clr) begin
			dot_q <= '0;
		end else if (ctrl.acc_en) begin
			dot_q <= dot_q + {{(mma_pkg::DOT_W - mma_pkg::PROD_W){prod_s2[mma_pkg::PROD_W-1]}},
				prod_s2};
		end
		if (ctrl.c_cap) begin
			c_q <= ac_rdata;
		end
		if (ctrl.scale_en) begin
			pa_q <= dot_q * alpha_gain;
			pb_q <= c_q * beta_gain;
		end
		if (ctrl.sum_en) begin
			result_value <= fits ? q_w[mma_pkg::RES_W-1:0]
				: (q_w[mma_pkg::Q_W-1] ? mma_pkg::RES_MIN : mma_pkg::RES_MAX);
			saturated    <= !fits;
		end
	end

	// beta*c is q.16, moved to q.24 before the sum; floor shift rounds to nearest
	always_comb begin
		pa_ext = {{(mma_pkg::SUM_W - mma_pkg::SA_W){pa_q[mma_pkg::SA_W-1]}}, pa_q};
		pb_ext = {{(mma_pkg::SUM_W - mma_pkg::SB_W - mma_pkg::BETA_SHIFT){pb_q[mma_pkg::SB_W-1]}},
			pb_q, {mma_pkg::BETA_SHIFT{1'b0}}};
		sum_w  = pa_ext + pb_ext + mma_pkg::ROUND_BIAS;
		q_w    = sum_w[mma_pkg::SUM_W-1:mma_pkg::FRAC_SHIFT];
		q_hi   = q_w[mma_pkg::Q_W-1:mma_pkg::RES_W-1];
		fits   = (&q_hi) || !(|q_hi);
	end

endmodule
`default_nettype wire

/* src/matrix_multiply_accumulate.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// c = alpha*a*b + beta*c element reads over stored q8.8 matrices
// a load is written at its accept edge; loads are taken one item per cycle
// while no read is in progress. A read holds off intake until its result
// is taken into the output register: one a/c memory read port walks the
// inner products, then c, then scaling; out-of-range reads skip these steps
// reset: registers return to defaults, stores are left uncleared
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate #(
	parameter int MAX_DIM = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// item channel
	input  wire logic                                  item_valid,
	output logic                                       item_ready,
	input  wire mma_pkg::mma_in_t                      item,
	// result channel
	output logic                                       result_valid,
	input  wire logic                                  result_ready,
	output mma_pkg::mma_out_t                          result,
	// configuration write channel
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [mma_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [mma_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(CELLS);
	localparam int ACW   = $clog2(2 * CELLS);

	// configuration registers
	logic [mma_pkg::DIM_W-1:0]         dim_m_q, dim_n_q, dim_k_q;
	logic signed [mma_pkg::GAIN_W-1:0] alpha_q, beta_q;

	// memory ports
	logic                      ac_we, ac_re, b_we, b_re;
	logic [ACW-1:0]            ac_waddr, ac_raddr;
	logic [AW-1:0]             b_waddr, b_raddr;
	logic [mma_pkg::ELEM_W-1:0] ac_rdata, b_rdata;

	mma_pkg::mma_ctrl_t                ctrl;
	logic signed [mma_pkg::RES_W-1:0]  mac_value;
	logic                              mac_sat;

	// output register
	mma_pkg::mma_out_t result_q, result_d;
	logic              result_valid_q, out_free, out_load;

	// register writes are always taken, unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_m_q <= mma_pkg::DIM_RST;
			dim_n_q <= mma_pkg::DIM_RST;
			dim_k_q <= mma_pkg::DIM_RST;
			alpha_q <= mma_pkg::ALPHA_RST;
			beta_q  <= mma_pkg::BETA_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mma_pkg::CFG_DIM_M: dim_m_q <= cfg_data[mma_pkg::DIM_W-1:0];
				mma_pkg::CFG_DIM_N: dim_n_q <= cfg_data[mma_pkg::DIM_W-1:0];
				mma_pkg::CFG_DIM_K: dim_k_q <= cfg_data[mma_pkg::DIM_W-1:0];
				mma_pkg::CFG_ALPHA: alpha_q <= cfg_data;
				mma_pkg::CFG_BETA:  beta_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: intake, addressing, read step control
	mma_seq #(
		.MAX_DIM(MAX_DIM)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.dim_m      (dim_m_q),
		.dim_n      (dim_n_q),
		.dim_k      (dim_k_q),
		.out_free   (out_free),
		.ac_we      (ac_we),
		.ac_waddr   (ac_waddr),
		.ac_re      (ac_re),
		.ac_raddr   (ac_raddr),
		.b_we       (b_we),
		.b_waddr    (b_waddr),
		.b_re       (b_re),
		.b_raddr    (b_raddr),
		.ctrl       (ctrl)
	);

	// a in the lower half, c in the upper half
	mma_ram #(
		.WIDTH(mma_pkg::ELEM_W),
		.DEPTH(2 * CELLS)
	) u_ram_ac (
		.clk   (clk),
		.we    (ac_we),
		.waddr (ac_waddr),
		.wdata (item.element_value),
		.re    (ac_re),
		.raddr (ac_raddr),
		.rdata (ac_rdata)
	);

	mma_ram #(
		.WIDTH(mma_pkg::ELEM_W),
		.DEPTH(CELLS)
	) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (item.element_value),
		.re    (b_re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// dot product, scaling, rounding and clipping
	mma_mac u_mac (
		.clk          (clk),
		.ctrl         (ctrl),
		.ac_rdata     (ac_rdata),
		.b_rdata      (b_rdata),
		.alpha_gain   (alpha_q),
		.beta_gain    (beta_q),
		.result_value (mac_value),
		.saturated    (mac_sat)
	);

	// out-of-range reads report zero with only the range flag set
	always_comb begin
		result_d.out_of_range = ctrl.oor;
		result_d.result_value = ctrl.oor ? '0 : mac_value;
		result_d.saturated    = ctrl.oor ? 1'b0 : mac_sat;
	end

	// result register frees the sequencer as soon as the slot can take the item
	assign out_free = !result_valid_q || result_ready;
	assign out_load = ctrl.done && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	// stores are only written by items taken while no read is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(ac_we || b_we) |-> item_ready)
		else $error("store write outside of intake");

	// a read holds off intake on the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.mode == mma_pkg::MODE_READ) |=> !item_ready)
		else $error("intake open while read in progress");

	// a finished read waiting for the output slot blocks intake
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.done |-> !item_ready)
		else $error("intake open while result pending");

	// result slot fills only from a finished read
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(ctrl.done))
		else $error("result without a finished read");

	// a clipped result sits at one of the two limits
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.saturated) |->
			(result.result_value == mma_pkg::RES_MAX || result.result_value == mma_pkg::RES_MIN))
		else $error("saturated result not at a limit");
`endif

endmodule
`default_nettype wire

/* verif/matrix_multiply_accumulate_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_tb
// self-checking bench for the q8.8 matrix multiply-accumulate block: loads of
// a, b and c elements and element reads run through valid/ready channels
// under several register settings and idle patterns, every read is predicted
// by an in-bench gemm element calculation and checked field by field
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_tb;

	import mma_pkg::*;

	localparam int DIM_MAX = 16;
	localparam int CELL_COUNT = DIM_MAX * DIM_MAX;
	// register index past the end of the register list, must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	// keep a margin for the last read to finish before config writes
	localparam int SETTLE_CYCLES = 25;

	// clock, reset and block ports
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	mma_in_t               item = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	mma_out_t              result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register copy seen by the element calculation
	logic [DIM_W-1:0]         cur_dim_m = DIM_RST;
	logic [DIM_W-1:0]         cur_dim_n = DIM_RST;
	logic [DIM_W-1:0]         cur_dim_k = DIM_RST;
	logic signed [GAIN_W-1:0] cur_alpha = ALPHA_RST;
	logic signed [GAIN_W-1:0] cur_beta  = BETA_RST;

	// matrix contents as accepted by the block
	logic signed [ELEM_W-1:0] elem_a [CELL_COUNT];
	logic signed [ELEM_W-1:0] elem_b [CELL_COUNT];
	logic signed [ELEM_W-1:0] elem_c [CELL_COUNT];

	// which cells the stimulus has already loaded, tracked at queue time
	bit a_loaded [CELL_COUNT];
	bit b_loaded [CELL_COUNT];
	bit c_loaded [CELL_COUNT];

	mma_in_t  pending_items[$];
	mma_out_t expected_elements[$];

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned extreme_pct = 10;
	int unsigned queued_count = 0;
	int unsigned error_count = 0;
	bit          item_taken = 1'b0;

	matrix_multiply_accumulate #(
		.MAX_DIM(DIM_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 20 ns clock
	initial begin
		forever #10 clk = ~clk;
	end

	// hard limit on the whole run
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	// dimension registers above the store size behave as the store size
	function automatic int unsigned clip_dim(input logic [DIM_W-1:0] d);
		return (d > DIM_MAX) ? DIM_MAX : int'(d);
	endfunction

	// one element of alpha*a*b + beta*c, rounded to q24.8 and clipped to 32 bits
	function automatic mma_out_t gemm_element(input int unsigned r, input int unsigned c);
		mma_out_t    res;
		longint      dot;
		longint      total;
		longint      q;
		int unsigned kd;
		int unsigned k;
		res = '0;
		if (r >= clip_dim(cur_dim_m) || c >= clip_dim(cur_dim_n)) begin
			res.out_of_range = 1'b1;
			return res;
		end
		kd = clip_dim(cur_dim_k);
		dot = 0;
		for (k = 0; k < kd; k++)
			dot += longint'(elem_a[r * DIM_MAX + k]) * longint'(elem_b[k * DIM_MAX + c]);
		// alpha*dot is q.24, beta*c is q.16 and moves up by 8 bits
		total = dot * longint'(cur_alpha)
			+ longint'(elem_c[r * DIM_MAX + c]) * longint'(cur_beta) * 256;
		// round to nearest, ties upward, by bias and floor shift
		q = (total + 32768) >>> 16;
		if (q > longint'(RES_MAX)) begin
			res.result_value = RES_MAX;
			res.saturated = 1'b1;
		end else if (q < longint'(RES_MIN)) begin
			res.result_value = RES_MIN;
			res.saturated = 1'b1;
		end else begin
			res.result_value = q[RES_W-1:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		error_count++;
	endtask

	// element values: extremes, small values or the full range
	function automatic logic signed [ELEM_W-1:0] pick_value();
		if ($urandom_range(99) < extreme_pct) begin
			case ($urandom_range(5))
				0, 1: return 16'sh8000;
				2, 3: return 16'sh7fff;
				4: return 16'sh0000;
				default: return 16'shffff;
			endcase
		end
		if ($urandom_range(1))
			return ELEM_W'(int'($urandom_range(1023)) - 512);
		return ELEM_W'($urandom);
	endfunction

	task automatic queue_item(input mode_t mode, input int unsigned r, input int unsigned c,
			input logic signed [ELEM_W-1:0] value);
		mma_in_t it;
		it.mode = mode;
		it.row_index = IDX_W'(r);
		it.col_index = IDX_W'(c);
		it.element_value = value;
		case (mode)
			MODE_LOAD_A: a_loaded[r * DIM_MAX + c] = 1'b1;
			MODE_LOAD_B: b_loaded[r * DIM_MAX + c] = 1'b1;
			MODE_LOAD_C: c_loaded[r * DIM_MAX + c] = 1'b1;
			default: ;
		endcase
		pending_items.push_back(it);
		queued_count++;
	endtask

	// an in-range read first gets every cell it depends on loaded
	task automatic queue_read(input int unsigned r, input int unsigned c);
		int unsigned kd;
		int unsigned k;
		if (r < clip_dim(cur_dim_m) && c < clip_dim(cur_dim_n)) begin
			kd = clip_dim(cur_dim_k);
			for (k = 0; k < kd; k++) begin
				if (!a_loaded[r * DIM_MAX + k])
					queue_item(MODE_LOAD_A, r, k, pick_value());
				if (!b_loaded[k * DIM_MAX + c])
					queue_item(MODE_LOAD_B, k, c, pick_value());
			end
			if (!c_loaded[r * DIM_MAX + c])
				queue_item(MODE_LOAD_C, r, c, pick_value());
		end
		// element value is ignored on a read, randomized anyway
		queue_item(MODE_READ, r, c, pick_value());
	endtask

	// config write, mirrored into the register copy at the accept edge
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (cfg_idx_t'(idx))
			CFG_DIM_M: cur_dim_m = data[DIM_W-1:0];
			CFG_DIM_N: cur_dim_n = data[DIM_W-1:0];
			CFG_DIM_K: cur_dim_k = data[DIM_W-1:0];
			CFG_ALPHA: cur_alpha = data;
			CFG_BETA:  cur_beta = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender holds off until every read has returned, then the block settles
	task automatic wait_for_drain();
		while (pending_items.size() != 0 || expected_elements.size() != 0 || item_valid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_all(input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] n,
			input logic [CFG_DATA_W-1:0] k, input logic [CFG_DATA_W-1:0] alpha,
			input logic [CFG_DATA_W-1:0] beta);
		write_register(CFG_DIM_M, m);
		write_register(CFG_DIM_N, n);
		write_register(CFG_DIM_K, k);
		write_register(CFG_ALPHA, alpha);
		write_register(CFG_BETA, beta);
	endtask

	// one random phase: drain, new registers, new idle pattern, random traffic
	task automatic run_phase(input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] n,
			input logic [CFG_DATA_W-1:0] k, input logic [CFG_DATA_W-1:0] alpha,
			input logic [CFG_DATA_W-1:0] beta, input int unsigned idle,
			input int unsigned stall, input int unsigned extremes, input int unsigned count);
		int unsigned target;
		int unsigned em;
		int unsigned en;
		wait_for_drain();
		write_all(m, n, k, alpha, beta);
		idle_pct = idle;
		stall_pct = stall;
		extreme_pct = extremes;
		em = clip_dim(cur_dim_m);
		en = clip_dim(cur_dim_n);
		target = queued_count + count;
		while (queued_count < target) begin
			if ($urandom_range(99) < 30)
				// stray load anywhere, overwrites earlier contents
				queue_item(mode_t'($urandom_range(2)), $urandom_range(15),
					$urandom_range(15), pick_value());
			else if (em > 0 && en > 0 && $urandom_range(1))
				queue_read($urandom_range(em - 1), $urandom_range(en - 1));
			else
				queue_read($urandom_range(15), $urandom_range(15));
		end
	endtask

	// driver: new item or idle at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (!item_valid || item_taken) begin
			item_taken = 1'b0;
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	// monitor: accepted items update the matrices, accepted results are checked
	always @(posedge clk) begin : monitor
		mma_out_t want;
		if (item_valid && item_ready) begin
			item_taken = 1'b1;
			case (item.mode)
				MODE_LOAD_A: elem_a[{item.row_index, item.col_index}] = item.element_value;
				MODE_LOAD_B: elem_b[{item.row_index, item.col_index}] = item.element_value;
				MODE_LOAD_C: elem_c[{item.row_index, item.col_index}] = item.element_value;
				MODE_READ: expected_elements.push_back(
					gemm_element(item.row_index, item.col_index));
				default: ;
			endcase
		end
		if (result_valid && result_ready) begin
			if (expected_elements.size() == 0) begin
				report_mismatch("result item with no read outstanding");
			end else begin
				want = expected_elements.pop_front();
				if (result.result_value !== want.result_value)
					report_mismatch($sformatf("result_value %0d, expected %0d",
						result.result_value, want.result_value));
				if (result.saturated !== want.saturated)
					report_mismatch($sformatf("saturated %b, expected %b",
						result.saturated, want.saturated));
				if (result.out_of_range !== want.out_of_range)
					report_mismatch($sformatf("out_of_range %b, expected %b",
						result.out_of_range, want.out_of_range));
			end
		end
	end

	// stimulus sequence
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: short inner dimension, most negative alpha, largest beta
		write_all(16'd16, 16'd16, 16'd2, 16'h8000, 16'h7fff);
		queue_item(MODE_LOAD_A, 0, 0, 16'sh8000);
		queue_item(MODE_LOAD_A, 0, 1, 16'sh7fff);
		queue_item(MODE_LOAD_B, 0, 0, 16'sh8000);
		queue_item(MODE_LOAD_B, 1, 0, 16'sh7fff);
		queue_item(MODE_LOAD_C, 0, 0, 16'sh8000);
		queue_read(0, 0);
		// far edges of every store
		queue_item(MODE_LOAD_A, 15, 0, 16'shffff);
		queue_item(MODE_LOAD_A, 15, 1, 16'sh0001);
		queue_item(MODE_LOAD_B, 0, 15, 16'sh7fff);
		queue_item(MODE_LOAD_B, 1, 15, 16'sh8000);
		queue_item(MODE_LOAD_C, 15, 15, 16'sh7fff);
		queue_read(15, 15);
		queue_item(MODE_LOAD_C, 15, 0, 16'sh0000);
		queue_read(15, 0);
		queue_item(MODE_LOAD_C, 0, 15, 16'shffff);
		queue_read(0, 15);
		// overwrite then reread, read value field at its extreme
		queue_item(MODE_LOAD_A, 0, 0, 16'sh0000);
		queue_item(MODE_READ, 0, 0, 16'sh7fff);

		// defaults with no idling, fills most of the stores
		run_phase(16'd16, 16'd16, 16'd16, 16'h0100, 16'h0000, 0, 0, 10, 200);
		// zero rows: every read out of range, zero inner dimension
		run_phase(16'd0, 16'd16, 16'd0, 16'h7fff, 16'h8000, 50, 0, 20, 60);
		// dimensions above the store size, extreme gains and values
		run_phase(16'd31, 16'd17, 16'd31, 16'h7fff, 16'h8000, 0, 50, 60, 220);
		// a write to an index past the list must change nothing
		wait_for_drain();
		write_register(CFG_UNUSED, 16'hffff);
		// upper data bits of the dimension writes are dropped
		run_phase(16'hffe5, 16'h0fe3, 16'h0021, 16'h8000, 16'h7fff, 9, 9, 30, 150);
		// zero columns: every read out of range
		run_phase(16'd16, 16'd0, 16'd16, 16'hffff, 16'h0001, 50, 50, 20, 50);
		// empty dot product, only beta times c remains
		run_phase(16'd16, 16'd16, 16'd0, 16'h1234, 16'hff00, 9, 9, 20, 150);
		// single element window, large values for saturation
		run_phase(16'd1, 16'd1, 16'd16, 16'h7fff, 16'h7fff, 0, 0, 80, 100);
		// full size, most negative gains, both sides idling
		run_phase(16'd16, 16'd16, 16'd16, 16'h8000, 16'h8000, 50, 50, 50, 250);

		wait_for_drain();
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
